### hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue: command and error codes,
// request and response transaction layouts, and the cell control group.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   // command codes; codes above query are treated as query
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
      logic [1:0]               error_code;
   } rsp_type;

   // broadcast to every cell, already qualified by the full and empty checks
   typedef struct packed {
      logic ins_front;
      logic ins_back;
      logic rem_front;
      logic rem_back;
   } dq_ctrl_type;

endpackage

### hw/rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the shifting chain: a word and an occupied flag,
// loaded from the left or right neighbor or from the pushed word.
// ----------------------------------------------------------------------------
module dq_cell
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dq_ctrl_type              ctrl,
   input  logic signed [WORD_W-1:0] push_word,
   input  logic signed [WORD_W-1:0] left_word,
   input  logic                     left_valid,
   input  logic signed [WORD_W-1:0] right_word,
   input  logic                     right_valid,
   output logic signed [WORD_W-1:0] word,
   output logic                     valid,
   output logic signed [WORD_W-1:0] tap
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic                     valid_ff;
   logic                     valid_in;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      if (ctrl.ins_front) begin
         word_in  = left_word;
         valid_in = left_valid;
      end else if (ctrl.ins_back) begin
         // first free cell takes the word
         if (!valid_ff && left_valid) begin
            word_in  = push_word;
            valid_in = 1'b1;
         end
      end else if (ctrl.rem_front) begin
         word_in  = right_word;
         valid_in = right_valid;
      end else if (ctrl.rem_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign valid = valid_ff;
   // only the last occupied cell puts its word on the back tap
   assign tap   = (valid_ff && !right_valid) ? word_ff : '0;

endmodule

### hw/rtl/dq_or_tree.sv
// ----------------------------------------------------------------------------
// dq_or_tree
// Registered binary OR tree that collects the single nonzero back tap of
// the cell chain; every tree level is registered.
// ----------------------------------------------------------------------------
module dq_or_tree
   import dq_pkg::*;
#(
   parameter int N = 16
)
(
   input  logic                     clock,
   input  logic signed [WORD_W-1:0] leaf [N],
   output logic signed [WORD_W-1:0] root
);

   localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
   localparam int P      = 1 << LEVELS;

   logic signed [WORD_W-1:0] leaf_pad [P];
   logic signed [WORD_W-1:0] node_ff  [1:P-1];

   genvar i;
   generate
      for (i = 0; i < P; i++) begin : g_pad
         if (i < N) begin : g_real
            assign leaf_pad[i] = leaf[i];
         end else begin : g_zero
            assign leaf_pad[i] = '0;
         end
      end

      for (i = 1; i < P; i++) begin : g_node
         if (2 * i >= P) begin : g_bottom
            always_ff @(posedge clock) begin
               node_ff[i] <= leaf_pad[2*i-P] | leaf_pad[2*i+1-P];
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               node_ff[i] <= node_ff[2*i] | node_ff[2*i+1];
            end
         end
      end
   endgenerate

   assign root = node_ff[1];

endmodule

### hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity double-ended queue of signed words held in a shifting
// chain of cells, front word always in cell 0.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type (command, value)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (front, back, occupancy,
//                                              flags, error code)
//
// one transaction at a time: accept cycle, then a wait in the busy state for the
// registered back-value tree, then the response
// req_stall stays high from accept until the response has been taken
// a stalled response holds its payload, the chain is not touched meanwhile
// reset clears the occupied flags, the count and the control state; word
// storage has no reset
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LAT    = $clog2(DEPTH);
   localparam int WAIT_W = $clog2(LAT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_RESP
   } state_type;

   state_type         state_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [1:0]        error_ff;
   logic [1:0]        error_in;

   logic        req_accept;
   logic        is_full;
   logic        is_empty;
   dq_ctrl_type ctrl;

   logic signed [WORD_W-1:0] cell_word  [DEPTH];
   logic                     cell_valid [DEPTH];
   logic signed [WORD_W-1:0] cell_tap   [DEPTH];
   logic signed [WORD_W-1:0] back_word;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);

   // command decode against the state before the command
   always_comb begin
      ctrl     = '0;
      count_in = count_ff;
      error_in = ERR_NONE;
      case (req_data.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (is_full) begin
               error_in = ERR_FULL;   // word dropped
            end else begin
               ctrl.ins_front = (req_data.command == CMD_PUSH_FRONT);
               ctrl.ins_back  = (req_data.command == CMD_PUSH_BACK);
               count_in       = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (is_empty) begin
               error_in = ERR_EMPTY;
            end else begin
               ctrl.rem_front = (req_data.command == CMD_POP_FRONT);
               ctrl.rem_back  = (req_data.command == CMD_POP_BACK);
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
            // query and unused codes
            if (is_empty) begin
               error_in = ERR_EMPTY;
            end
         end
      endcase
      if (!req_accept) begin
         ctrl = '0;
      end
   end

   // cell chain: cell 0 is the front; left of cell 0 is the pushed word
   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [WORD_W-1:0] left_word;
         logic                     left_valid;
         logic signed [WORD_W-1:0] right_word;
         logic                     right_valid;

         if (i == 0) begin : g_first
            assign left_word  = req_data.value;
            assign left_valid = 1'b1;
         end else begin : g_mid_l
            assign left_word  = cell_word[i-1];
            assign left_valid = cell_valid[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_word  = '0;
            assign right_valid = 1'b0;
         end else begin : g_mid_r
            assign right_word  = cell_word[i+1];
            assign right_valid = cell_valid[i+1];
         end

         dq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .push_word   (req_data.value),
            .left_word   (left_word),
            .left_valid  (left_valid),
            .right_word  (right_word),
            .right_valid (right_valid),
            .word        (cell_word[i]),
            .valid       (cell_valid[i]),
            .tap         (cell_tap[i])
         );
      end
   endgenerate

   // back value: only the last occupied cell drives a nonzero tap
   dq_or_tree #(
      .N (DEPTH)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_tap),
      .root  (back_word)
   );

   // sequencer: accept, wait for the tree, hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         count_ff <= '0;
         error_ff <= ERR_NONE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_BUSY;
                  wait_ff  <= WAIT_W'(LAT);
                  count_ff <= count_in;
                  error_ff <= error_in;
               end
            end
            ST_BUSY: begin
               if (wait_ff == WAIT_W'(1)) begin
                  state_ff <= ST_RESP;
               end
               wait_ff <= wait_ff - WAIT_W'(1);
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // response fields come straight from held registers
   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_data.front_value  = cell_valid[0] ? cell_word[0] : '0;
   assign rsp_data.back_value   = back_word;
   assign rsp_data.occupancy    = OCC_W'(count_ff);
   assign rsp_data.is_empty     = is_empty;
   assign rsp_data.is_full      = is_full;
   assign rsp_data.error_code   = error_ff;

endmodule

### hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
   import dq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // the response never shows in the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response right after accept");

   // no new transaction while a response is pending
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // an empty error always reports an empty queue
   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == ERR_EMPTY |-> rsp_data.is_empty &&
         rsp_data.front_value == '0 && rsp_data.back_value == '0)
      else $error("empty error on nonempty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

### dv/dq_response_checker.sv
// ----------------------------------------------------------------------------
// dq_response_checker
// Watches the request and response channels of the double-ended queue,
// predicts the status reported after every accepted command and compares
// each accepted response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dq_response_checker
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   // predicted deque contents, circular with front and back indices
   logic signed [WORD_W-1:0] word_store [DEPTH];
   int                       front_idx;
   int                       back_idx;
   int                       stored_count;

   rsp_type                  expected_status_q [$];
   rsp_type                  want;

   function automatic rsp_type predict_deque(input req_type item);
      rsp_type    status;
      logic [1:0] err;
      err = ERR_NONE;
      case (item.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (stored_count >= DEPTH) begin
               err = ERR_FULL;
            end else if (stored_count == 0) begin
               front_idx     = 0;
               back_idx      = 0;
               word_store[0] = item.value;
               stored_count  = 1;
            end else if (item.command == CMD_PUSH_FRONT) begin
               front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
               word_store[front_idx] = item.value;
               stored_count++;
            end else begin
               back_idx = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
               word_store[back_idx] = item.value;
               stored_count++;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (stored_count == 0) begin
               err = ERR_EMPTY;
            end else if (stored_count == 1) begin
               front_idx    = 0;
               back_idx     = 0;
               stored_count = 0;
            end else begin
               if (item.command == CMD_POP_FRONT)
                  front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
               else
                  back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
               stored_count--;
            end
         end
         default: begin
            // query and the unused codes
            if (stored_count == 0)
               err = ERR_EMPTY;
         end
      endcase
      if (stored_count == 0) begin
         status.front_value = '0;
         status.back_value  = '0;
      end else begin
         status.front_value = word_store[front_idx];
         status.back_value  = word_store[back_idx];
      end
      status.occupancy  = OCC_W'(stored_count);
      status.is_empty   = (stored_count == 0);
      status.is_full    = (stored_count == DEPTH);
      status.error_code = err;
      return status;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: mismatch on %s, expected %0h, actual %0h",
                  $time, field, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         front_idx      = 0;
         back_idx       = 0;
         stored_count   = 0;
         expected_status_q.delete();
         pending_count  = 0;
         mismatch_count = 0;
      end else begin
         // a response never belongs to a command accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               $display("%0t: mismatch, response %0h with nothing expected",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_status_q[0];
               expected_status_q.delete(0);
               check_field("front_value", want.front_value, rsp_data.front_value);
               check_field("back_value", want.back_value, rsp_data.back_value);
               check_field("occupancy", WORD_W'(want.occupancy),
                           WORD_W'(rsp_data.occupancy));
               check_field("is_empty", WORD_W'(want.is_empty),
                           WORD_W'(rsp_data.is_empty));
               check_field("is_full", WORD_W'(want.is_full),
                           WORD_W'(rsp_data.is_full));
               check_field("error_code", WORD_W'(want.error_code),
                           WORD_W'(rsp_data.error_code));
            end
         end
         if (req_valid && !req_stall)
            expected_status_q = {expected_status_q, predict_deque(req_data)};
         pending_count = expected_status_q.size();
      end
   end

endmodule

### dv/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Stimulus and verdict for the double-ended queue: a directed run over the
// empty, single-word and full cases, then phases of random commands biased
// toward filling, draining or churning, with random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam int         QUEUE_DEPTH   = 16;
   localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID = 3'd6;
   localparam logic [2:0] CMD_LAST_CODE = 3'd7;
   localparam int         PHASE_COUNT   = 17;
   localparam int         PHASE_ITEMS   = 50;

   // command mix of one random phase
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int      mismatch_count;
   int      pending_count;

   // idle bursts on the sender and stall bursts on the receiver
   logic    send_idle;
   logic    stall_idle;
   int      stall_left;

   double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dq_response_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // word to push: half the time random, else the largest, the smallest, zero or minus one
   function automatic logic signed [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // command drawn from the mix of the phase, a few queries and unused codes
   function automatic logic [2:0] pick_command(input mix_type mix);
      int roll;
      int push_share;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  push_share = 80;
         MIX_DRAIN: push_share = 20;
         default:   push_share = 50;
      endcase
      if (roll < 6)
         return 3'($urandom_range(CMD_QUERY, CMD_LAST_CODE));
      else if (roll < 6 + push_share * 94 / 100)
         return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
         return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
   endfunction

   // one transaction on the request channel, returns right after acceptance
   task automatic send_command(input logic [2:0] cmd, input logic signed [WORD_W-1:0] word);
      int gap;
      gap = 0;
      if (send_idle && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_data.command = cmd;
      req_data.value   = word;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // sender holds off until every predicted response has been taken
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // receiver stall bursts, changed at the falling edge
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (stall_idle && stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (stall_idle && $urandom_range(0, 11) == 0) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(0, 17);
         end else begin
            rsp_stall  = 1'b0;
            stall_left = 0;
         end
      end
   end

   initial begin
      int      cycles;
      mix_type mix;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      send_idle  = 1'b0;
      stall_idle = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      send_idle  = 1'b1;
      stall_idle = 1'b1;
      // query and pops on an empty queue, unused codes act as query
      send_command(CMD_QUERY, pick_value());
      send_command(CMD_POP_FRONT, pick_value());
      send_command(CMD_POP_BACK, pick_value());
      send_command(CMD_SPARE_LO, pick_value());
      send_command(CMD_LAST_CODE, pick_value());
      // push into empty, then pop down to the last word and pop that one too
      send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_command(CMD_PUSH_BACK, 32'sh8000_0000);
      send_command(CMD_POP_FRONT, pick_value());
      send_command(CMD_POP_BACK, pick_value());
      // fill to capacity from both ends, then pushes into a full queue
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_command((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                      (i == 0) ? '0 : (i == 1) ? -32'sd1 : pick_value());
      send_command(CMD_PUSH_FRONT, pick_value());
      send_command(CMD_PUSH_BACK, pick_value());
      send_command(CMD_SPARE_MID, pick_value());

      // sender pause until the block has answered everything
      wait_for_responses();

      // random phases cycling fill, drain and churn so the queue keeps
      // crossing full and empty and the indices wrap
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mix = mix_type'(phase % 3);
         // one stretch without idling in the middle, none in the last part
         send_idle  = (phase != 6) && (phase < PHASE_COUNT - 3);
         stall_idle = send_idle;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_command(pick_command(mix), pick_value());
         if (phase == 8)
            wait_for_responses();
      end

      @(negedge clock);
      req_valid = 1'b0;

      // drain with a limit, then a few more cycles for stray responses
      cycles = 0;
      while (pending_count != 0 && cycles < 5000) begin
         @(negedge clock);
         cycles++;
      end
      repeat (20) @(negedge clock);

      if (pending_count != 0)
         $display("%0t: %0d expected responses never arrived", $time, pending_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
